### rtl/shas_pkg.sv
// ----------------------------------------------------------------------------
// shas_pkg
// Shared types and codes for the shared-array multi-stack.
// ----------------------------------------------------------------------------
`default_nettype none

package shas_pkg;

    // Field widths fixed by the beat format
    localparam int VALUE_W  = 32;
    localparam int SEL_W    = 2;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    // Data word returned by a pop of an empty stack
    localparam logic [VALUE_W-1:0] DATA_UNDERFLOW = 32'h7FFF_FFFF;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Command group from the sequencer to the entry store
    typedef struct packed {
        logic rd_en;
        logic link_we;
        logic data_we;
    } t_store_cmd;

endpackage

`default_nettype wire

### rtl/shas_store.sv
// ----------------------------------------------------------------------------
// shas_store
// Entry store: link and data memories with registered reads. A fill
// count marks the entries written so far; links at or above it read as the
// reset chain (entry i links i+1, the last links null).
// ----------------------------------------------------------------------------
`default_nettype none

module shas_store #(
    parameter int NUM_ENTRIES = 128
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire shas_pkg::t_store_cmd            i_cmd,
    input  wire [$clog2(NUM_ENTRIES)-1:0]        i_rd_addr,
    input  wire [$clog2(NUM_ENTRIES)-1:0]        i_wr_addr,
    input  wire [$clog2(NUM_ENTRIES):0]          i_wr_link,
    input  wire [shas_pkg::VALUE_W-1:0]          i_wr_data,
    output logic [$clog2(NUM_ENTRIES):0]         o_link,
    output logic [shas_pkg::VALUE_W-1:0]         o_data
);

    localparam int AW = $clog2(NUM_ENTRIES);
    localparam int LW = AW + 1;
    localparam int FW = $clog2(NUM_ENTRIES + 1);
    localparam logic [LW-1:0] LINK_NULL = {1'b1, {AW{1'b0}}};

    logic [LW-1:0]                 r_link_mem [NUM_ENTRIES];
    logic [shas_pkg::VALUE_W-1:0]  r_data_mem [NUM_ENTRIES];

    logic [LW-1:0]                 r_link_q;
    logic [shas_pkg::VALUE_W-1:0]  r_data_q;
    logic [LW-1:0]                 r_dflt;
    logic                          r_written;
    logic [FW-1:0]                 r_fill;
    logic [FW-1:0]                 n_fill;
    logic [FW-1:0]                 rd_next;
    logic [LW-1:0]                 n_dflt;

    // Memory write port
    always_ff @(posedge i_clk) begin
        if (i_cmd.link_we) begin
            r_link_mem[i_wr_addr] <= i_wr_link;
        end
        if (i_cmd.data_we) begin
            r_data_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Memory read port, registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_link_q  <= r_link_mem[i_rd_addr];
            r_data_q  <= r_data_mem[i_rd_addr];
            r_dflt    <= n_dflt;
            r_written <= (FW'(i_rd_addr) < r_fill);
        end
    end

    // Reset-chain link for an entry not yet written
    always_comb begin
        rd_next = FW'(i_rd_addr) + FW'(1);
        if (rd_next < FW'(NUM_ENTRIES)) begin
            n_dflt = {1'b0, rd_next[AW-1:0]};
        end else begin
            n_dflt = LINK_NULL;
        end
    end

    // Fill count: writes land at or below it, so it only steps by one
    always_comb begin
        n_fill = r_fill;
        if (i_cmd.link_we && (FW'(i_wr_addr) == r_fill)) begin
            n_fill = r_fill + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_link = r_written ? r_link_q : r_dflt;
    assign o_data = r_data_q;

endmodule

`default_nettype wire

### rtl/shas_heads.sv
// ----------------------------------------------------------------------------
// shas_heads
// Per-stack head pointers and the free-list head, held in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module shas_heads #(
    parameter int NUM_ENTRIES = 128,
    parameter int NUM_STACKS  = 3
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire [shas_pkg::SEL_W-1:0]         i_rd_sel,
    input  wire                               i_wr_en,
    input  wire [shas_pkg::SEL_W-1:0]         i_wr_sel,
    input  wire [$clog2(NUM_ENTRIES):0]       i_wr_stack_head,
    input  wire [$clog2(NUM_ENTRIES):0]       i_wr_free_head,
    output logic [$clog2(NUM_ENTRIES):0]      o_rd_head,
    output logic [$clog2(NUM_ENTRIES):0]      o_free_head
);

    localparam int AW = $clog2(NUM_ENTRIES);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] LINK_NULL = {1'b1, {AW{1'b0}}};

    logic [LW-1:0] r_stack_head [NUM_STACKS];
    logic [LW-1:0] r_free_head;

    // Head registers: all stacks empty, free list starts at entry 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_stack_head[i] <= LINK_NULL;
            end
            r_free_head <= '0;
        end else if (i_wr_en) begin
            for (int i = 0; i < NUM_STACKS; i++) begin
                if (32'(i_wr_sel) == i) begin
                    r_stack_head[i] <= i_wr_stack_head;
                end
            end
            r_free_head <= i_wr_free_head;
        end
    end

    // Head of the selected stack; a stack beyond the set reads as empty
    always_comb begin
        o_rd_head = LINK_NULL;
        for (int i = 0; i < NUM_STACKS; i++) begin
            if (32'(i_rd_sel) == i) begin
                o_rd_head = r_stack_head[i];
            end
        end
    end

    assign o_free_head = r_free_head;

endmodule

`default_nettype wire

### rtl/shared_array_multi_stack.sv
// ----------------------------------------------------------------------------
// shared_array_multi_stack
// Several stacks in one linked entry store with a shared free list.
// ----------------------------------------------------------------------------
// Each input beat is a push or a pop to one stack and gives one result beat.
// In the accept cycle (idle state) the chosen entry (free-list head for a
// push, stack top for a pop) is read from the link and data memories; the
// exec state then applies the update, writes back and loads the output
// register, waiting there while a stalled master side still holds the last
// result. No new beat is accepted until exec is done. Entries not yet
// written are tracked by a fill count, so there is no clearing pass after
// reset. A push with no free entry reports overflow, a pop of an empty stack
// reports underflow with data 0x7FFFFFFF, and a stack select beyond the set
// does both.
// ----------------------------------------------------------------------------
`default_nettype none

module shared_array_multi_stack #(
    parameter int NUM_ENTRIES = 128,
    parameter int NUM_STACKS  = 3
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [31:0] i_s_tdata,   // [31:0] value
    input  wire  [2:0]  i_s_tuser,   // [0] mode, [2:1] stack_sel
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] data
    output logic [3:0]  o_m_tuser    // [1:0] status, [2] store_full, [3] stack_empty
);

    localparam int AW = $clog2(NUM_ENTRIES);
    localparam int LW = AW + 1;

    shas_pkg::t_state     r_state;
    shas_pkg::t_state     n_state;
    shas_pkg::t_store_cmd store_cmd;

    logic                            accept;
    logic                            done;
    logic                            in_mode;
    logic [shas_pkg::SEL_W-1:0]      in_sel;
    logic                            in_sel_ok;
    logic [LW-1:0]                   rd_head;
    logic [LW-1:0]                   free_head;
    logic [LW-1:0]                   pick;

    logic                            r_mode;
    logic [shas_pkg::SEL_W-1:0]      r_sel;
    logic [shas_pkg::VALUE_W-1:0]    r_value;
    logic                            r_ok;
    logic                            r_sel_ok;
    logic [AW-1:0]                   r_addr;
    logic [LW-1:0]                   r_head;

    logic [LW-1:0]                   link_q;
    logic [shas_pkg::VALUE_W-1:0]    data_q;
    logic [LW-1:0]                   new_head;
    logic [LW-1:0]                   new_free;
    logic [LW-1:0]                   wr_link;
    logic [shas_pkg::VALUE_W-1:0]    res_data;
    logic [shas_pkg::STATUS_W-1:0]   res_status;

    logic                            r_out_valid;
    logic [31:0]                     r_out_data;
    logic [3:0]                      r_out_user;

    // Input beat decode
    assign in_mode   = i_s_tuser[0];
    assign in_sel    = i_s_tuser[2:1];
    assign in_sel_ok = 32'(in_sel) < NUM_STACKS;
    assign pick      = (in_mode == shas_pkg::MODE_PUSH) ? free_head : rd_head;

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            shas_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = shas_pkg::ST_EXEC;
            end
            shas_pkg::ST_EXEC: begin
                if (!r_out_valid || i_m_tready) n_state = shas_pkg::ST_IDLE;
            end
            default: n_state = shas_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        o_s_tready = 1'b0;
        done       = 1'b0;
        case (r_state)
            shas_pkg::ST_IDLE: o_s_tready = 1'b1;
            shas_pkg::ST_EXEC: done = !r_out_valid || i_m_tready;
            default: begin
                o_s_tready = 1'b0;
                done       = 1'b0;
            end
        endcase
    end

    assign accept = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shas_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the item and what it addresses
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= in_mode;
            r_sel    <= in_sel;
            r_value  <= i_s_tdata;
            r_sel_ok <= in_sel_ok;
            r_ok     <= in_sel_ok && !pick[LW-1];
            r_addr   <= pick[AW-1:0];
            r_head   <= rd_head;
        end
    end

    // Relink: push links the free head above the top, pop returns the top
    always_comb begin
        new_head   = r_head;
        new_free   = free_head;
        wr_link    = r_head;
        res_data   = '0;
        res_status = shas_pkg::STATUS_OK;
        if (r_mode == shas_pkg::MODE_PUSH) begin
            if (r_ok) begin
                new_free = link_q;
                new_head = {1'b0, r_addr};
                wr_link  = r_head;
            end else begin
                res_status = shas_pkg::STATUS_OVERFLOW;
            end
        end else begin
            if (r_ok) begin
                new_head = link_q;
                new_free = {1'b0, r_addr};
                wr_link  = free_head;
                res_data = data_q;
            end else begin
                res_status = shas_pkg::STATUS_UNDERFLOW;
                res_data   = shas_pkg::DATA_UNDERFLOW;
            end
        end
    end

    assign store_cmd.rd_en   = accept;
    assign store_cmd.link_we = done && r_ok;
    assign store_cmd.data_we = done && r_ok && (r_mode == shas_pkg::MODE_PUSH);

    shas_store #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (store_cmd),
        .i_rd_addr (pick[AW-1:0]),
        .i_wr_addr (r_addr),
        .i_wr_link (wr_link),
        .i_wr_data (r_value),
        .o_link    (link_q),
        .o_data    (data_q)
    );

    shas_heads #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .NUM_STACKS  (NUM_STACKS)
    ) u_heads (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rd_sel        (in_sel),
        .i_wr_en         (done && r_ok),
        .i_wr_sel        (r_sel),
        .i_wr_stack_head (new_head),
        .i_wr_free_head  (new_free),
        .o_rd_head       (rd_head),
        .o_free_head     (free_head)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= res_data;
            r_out_user <= {(!r_sel_ok) || new_head[LW-1], new_free[LW-1], res_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    // Checks
    a_push_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_ok && (r_mode == shas_pkg::MODE_PUSH)) |=> !o_m_tuser[3])
        else $error("stack reads empty after a successful push");

    a_pop_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && r_ok && (r_mode == shas_pkg::MODE_POP))
            |=> (o_m_tuser[1:0] == shas_pkg::STATUS_OK))
        else $error("successful pop reported a fault status");

    a_underflow_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[1:0] == shas_pkg::STATUS_UNDERFLOW))
            |-> (o_m_tdata == shas_pkg::DATA_UNDERFLOW))
        else $error("underflow beat without the underflow data word");

    a_no_accept_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("second item accepted while one is in the store cycle");

endmodule

`default_nettype wire

### dv/shared_array_multi_stack_test.sv
// ----------------------------------------------------------------------------
// shared_array_multi_stack_test
// Self-checking testbench for the shared-array multi-stack.
// ----------------------------------------------------------------------------
// Push and pop beats go in on the slave side. A local copy of the store
// (linked free list, per-stack heads, link and data words) predicts each
// result at the moment its beat is accepted. The checker compares every
// result beat, field by field, with the oldest prediction. Directed cases
// cover empty pops, the unused stack select and extreme data words. Random
// phases fill the store to overflow, drain it and mix both, under four
// idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shared_array_multi_stack_test;

    localparam int NUM_ENTRIES = 128;
    localparam int NUM_STACKS  = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 20;
    localparam int SEL_WIDTH   = shas_pkg::SEL_W;

    // Select code beyond the last stack
    localparam logic [shas_pkg::SEL_W-1:0] SEL_UNUSED = 2'd3;
    // Link code that points nowhere
    localparam logic [7:0] LINK_NONE = 8'hFF;

    typedef struct {
        logic [shas_pkg::VALUE_W-1:0]  data;
        logic [shas_pkg::STATUS_W-1:0] status;
        logic                          full;
        logic                          empty;
    } t_result;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_s_tvalid = 1'b0;
    logic [31:0]        i_s_tdata  = '0;
    logic [2:0]         i_s_tuser  = '0;
    logic               i_m_tready = 1'b0;
    logic               o_s_tready;
    logic               o_m_tvalid;
    logic [31:0]        o_m_tdata;
    logic [3:0]         o_m_tuser;

    // Predicted store contents
    logic [shas_pkg::VALUE_W-1:0] model_data [NUM_ENTRIES];
    logic [7:0]         model_link [NUM_ENTRIES];
    logic [7:0]         model_head [NUM_STACKS];
    logic [7:0]         model_free;
    int                 model_depth [NUM_STACKS];

    t_result            pending_results [$];
    int                 fail_count  = 0;
    int                 cycle_count = 0;
    int                 src_idle_pct = 0;
    int                 snk_stall_pct = 0;

    shared_array_multi_stack #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .NUM_STACKS  (NUM_STACKS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // [31:0] value
        .i_s_tuser  (i_s_tuser),   // [0] mode, [2:1] stack_sel
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // [31:0] data
        .o_m_tuser  (o_m_tuser)    // [1:0] status, [2] store_full, [3] stack_empty
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic slot_valid(logic [7:0] p);
        return p < NUM_ENTRIES;
    endfunction

    // Reset state of the predicted store
    function automatic void stack_store_clear();
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            model_data[i] = '0;
            model_link[i] = (i + 1 < NUM_ENTRIES) ? 8'(i + 1) : LINK_NONE;
        end
        for (int s = 0; s < NUM_STACKS; s++) begin
            model_head[s]  = LINK_NONE;
            model_depth[s] = 0;
        end
        model_free = '0;
    endfunction

    // Apply one operation to the predicted store and return its result
    function automatic t_result stack_store_apply(logic mode,
                                                  logic [shas_pkg::SEL_W-1:0] sel,
                                                  logic [shas_pkg::VALUE_W-1:0] value);
        t_result    r;
        logic [7:0] e;
        logic       sel_ok;
        sel_ok   = sel < NUM_STACKS;
        r.data   = '0;
        r.status = shas_pkg::STATUS_OK;
        r.empty  = 1'b1;
        if (mode == shas_pkg::MODE_PUSH) begin
            if (!sel_ok || !slot_valid(model_free)) begin
                r.status = shas_pkg::STATUS_OVERFLOW;
            end else begin
                e               = model_free;
                model_free      = model_link[e];
                model_link[e]   = model_head[sel];
                model_head[sel] = e;
                model_data[e]   = value;
                model_depth[sel]++;
            end
        end else begin
            if (!sel_ok || !slot_valid(model_head[sel])) begin
                r.status = shas_pkg::STATUS_UNDERFLOW;
                r.data   = shas_pkg::DATA_UNDERFLOW;
            end else begin
                e               = model_head[sel];
                model_head[sel] = model_link[e];
                model_link[e]   = model_free;
                model_free      = e;
                r.data          = model_data[e];
                model_depth[sel]--;
            end
        end
        if (sel_ok)
            r.empty = !slot_valid(model_head[sel]);
        r.full = !slot_valid(model_free);
        return r;
    endfunction

    // Send one beat; valid stays high afterwards so the next beat can follow
    task automatic send_op(logic mode, logic [shas_pkg::SEL_W-1:0] sel,
                           logic [shas_pkg::VALUE_W-1:0] value);
        int gap;
        begin
            gap = 0;
            while ($urandom_range(0, 99) < src_idle_pct && gap < 64)
                gap++;
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= $urandom;
                i_s_tuser  <= 3'($urandom);
                repeat (gap) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= value;
            i_s_tuser  <= {sel, mode};
            do @(posedge i_clk); while (!o_s_tready);
            pending_results.push_back(stack_store_apply(mode, sel, value));
        end
    endtask

    // Result checker and receiver stalls
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: data %h tuser %h",
                       o_m_tdata, o_m_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.data) begin
                    $error("data: expected %h, actual %h", want.data, o_m_tdata);
                    fail_count++;
                end
                if (o_m_tuser[1:0] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_m_tuser[1:0]);
                    fail_count++;
                end
                if (o_m_tuser[2] !== want.full) begin
                    $error("store_full: expected %b, actual %b", want.full, o_m_tuser[2]);
                    fail_count++;
                end
                if (o_m_tuser[3] !== want.empty) begin
                    $error("stack_empty: expected %b, actual %b", want.empty, o_m_tuser[3]);
                    fail_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Pops of stacks that were never pushed
    task automatic test_empty_pops();
        for (int s = 0; s < NUM_STACKS; s++)
            send_op(shas_pkg::MODE_POP, SEL_WIDTH'(s), $urandom);
    endtask

    // Select beyond the last stack: overflow on push, underflow on pop
    task automatic test_bad_select();
        send_op(shas_pkg::MODE_PUSH, SEL_UNUSED, 32'h1234_5678);
        send_op(shas_pkg::MODE_POP, SEL_UNUSED, $urandom);
        send_op(shas_pkg::MODE_PUSH, 2'd0, 32'hCAFE_0001);
        send_op(shas_pkg::MODE_POP, SEL_UNUSED, $urandom);
        send_op(shas_pkg::MODE_POP, 2'd0, $urandom);
    endtask

    // Extreme data words through every stack, then pop stacks 1 and 2 past the bottom
    task automatic test_extremes();
        send_op(shas_pkg::MODE_PUSH, 2'd0, 32'h8000_0000);
        send_op(shas_pkg::MODE_PUSH, 2'd1, 32'h7FFF_FFFF);
        send_op(shas_pkg::MODE_PUSH, 2'd2, 32'h0000_0000);
        send_op(shas_pkg::MODE_PUSH, 2'd0, 32'hFFFF_FFFF);
        send_op(shas_pkg::MODE_PUSH, 2'd2, 32'h5555_AAAA);
        send_op(shas_pkg::MODE_POP, 2'd0, 32'hFFFF_FFFF);
        send_op(shas_pkg::MODE_POP, 2'd0, 32'h0000_0000);
        send_op(shas_pkg::MODE_POP, 2'd1, $urandom);
        send_op(shas_pkg::MODE_POP, 2'd1, $urandom);
        send_op(shas_pkg::MODE_POP, 2'd2, $urandom);
        send_op(shas_pkg::MODE_POP, 2'd2, $urandom);
        send_op(shas_pkg::MODE_POP, 2'd2, $urandom);
    endtask

    // Fill the store to overflow, then drain every stack past empty
    task automatic test_fill_drain();
        begin
            while (slot_valid(model_free))
                send_op(shas_pkg::MODE_PUSH,
                        SEL_WIDTH'($urandom_range(0, NUM_STACKS - 1)), $urandom);
            repeat (3)
                send_op(shas_pkg::MODE_PUSH, SEL_WIDTH'($urandom_range(0, 3)), $urandom);
            send_op(shas_pkg::MODE_POP, 2'd1, $urandom);
            send_op(shas_pkg::MODE_PUSH, 2'd1, $urandom);
            for (int s = 0; s < NUM_STACKS; s++) begin
                while (model_depth[s] > 0)
                    send_op(shas_pkg::MODE_POP, SEL_WIDTH'(s), $urandom);
                send_op(shas_pkg::MODE_POP, SEL_WIDTH'(s), $urandom);
            end
        end
    endtask

    // Random mix with a given share of pushes; a few beats use the unused select
    task automatic test_random_mix(int count, int push_pct);
        logic                       mode;
        logic [shas_pkg::SEL_W-1:0] sel;
        begin
            repeat (count) begin
                mode = ($urandom_range(0, 99) < push_pct) ? shas_pkg::MODE_PUSH
                                                          : shas_pkg::MODE_POP;
                sel  = ($urandom_range(0, 99) < 5) ? SEL_UNUSED
                                                   : SEL_WIDTH'($urandom_range(0, 2));
                send_op(mode, sel, $urandom);
            end
        end
    endtask

    // Test sequence
    initial begin
        stack_store_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // No idling
        test_empty_pops();
        test_bad_select();
        test_extremes();
        test_fill_drain();
        test_random_mix(120, 60);

        // Sender idle most cycles
        src_idle_pct  = 76;
        snk_stall_pct = 0;
        test_random_mix(150, 85);
        test_random_mix(150, 20);

        // Receiver stalling most cycles
        src_idle_pct  = 0;
        snk_stall_pct = 76;
        test_random_mix(150, 85);
        test_random_mix(150, 20);

        // Both sides idling now and then
        src_idle_pct  = 18;
        snk_stall_pct = 18;
        test_fill_drain();
        test_random_mix(200, 70);
        test_random_mix(200, 45);

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### files.f
rtl/shas_pkg.sv
rtl/shas_store.sv
rtl/shas_heads.sv
rtl/shared_array_multi_stack.sv
dv/shared_array_multi_stack_test.sv
